[hdl/mrjd_pkg.sv]
// Shared types and codes for the multi-ring job dispatcher.
package mrjd_pkg;

  localparam int unsigned JobW    = 32;
  localparam int unsigned QlenW   = 7;
  localparam int unsigned TidW    = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned UsedW   = 4;

  localparam logic [QlenW-1:0] QlenReset = 7'd64;

  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  localparam logic [StatW-1:0] StatEnqueued = 2'd0;
  localparam logic [StatW-1:0] StatFull     = 2'd1;
  localparam logic [StatW-1:0] StatDequeued = 2'd2;
  localparam logic [StatW-1:0] StatEmpty    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR,
    ST_DATA
  } mrjd_state_e;

  typedef struct packed {
    logic load;       // take the request on the ports
    logic ptr_step;   // pointer record is valid: commit the ring update
    logic data_step;  // dequeued entry is valid: report it
  } mrjd_cmd_t;

  typedef struct packed {
    logic item_deq;    // request on the ports is a dequeue
    logic none_found;  // request on the ports finds every ring empty
    logic deq_q;       // request in flight is a dequeue
  } mrjd_stat_t;

endpackage

[hdl/mrjd_ctrl.sv]
// Sequencer for the multi-ring job dispatcher.
module mrjd_ctrl
  import mrjd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  mrjd_stat_t stat_i,
  output mrjd_cmd_t  cmd_o,
  output logic       busy
);

  mrjd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          // A dequeue that finds nothing is answered at once.
          if (!(stat_i.item_deq && stat_i.none_found)) begin
            state_d = ST_PTR;
          end
        end
      end
      ST_PTR: begin
        cmd_o.ptr_step = 1'b1;
        state_d = stat_i.deq_q ? ST_DATA : ST_IDLE;
      end
      ST_DATA: begin
        cmd_o.data_step = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/mrjd_datapath.sv]
// Ring pointers, job storage, ring selection and result registers.
module mrjd_datapath
  import mrjd_pkg::*;
#(
  parameter int unsigned PREFERRED_RINGS = 8,
  parameter int unsigned RING_DEPTH      = 64,
  parameter int unsigned JOB_ID_BITS     = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [QlenW-1:0] cfg_ring_len_i,
  input  logic             func_i,
  input  logic [TidW-1:0]  thread_id_i,
  input  logic [JobW-1:0]  job_id_i,
  input  mrjd_cmd_t        cmd_i,
  output mrjd_stat_t       stat_o,
  output logic             done_o,
  output logic [StatW-1:0] status_o,
  output logic [JobW-1:0]  job_out_o,
  output logic [UsedW-1:0] ring_used_o
);

  localparam int unsigned NumRings   = PREFERRED_RINGS + 1;
  localparam int unsigned RingW      = $clog2(NumRings);
  localparam int unsigned PtrW       = $clog2(RING_DEPTH);
  localparam int unsigned RecW       = 3 * PtrW;
  localparam int unsigned StoreW     = (JOB_ID_BITS < JobW) ? JOB_ID_BITS : JobW;
  localparam int unsigned StoreDepth = NumRings << PtrW;

  // Usable ring capacity: next power of two of the length, at least four,
  // limited to the physical ring depth, minus one.
  function automatic logic [PtrW-1:0] ring_cap(input logic [QlenW-1:0] qlen);
    int unsigned size;
    size = 4;
    for (int i = 0; i < QlenW; i++) begin
      if (size < int'(qlen) && size < RING_DEPTH) begin
        size = size << 1;
      end
    end
    if (size > RING_DEPTH) begin
      size = RING_DEPTH;
    end
    return PtrW'(size - 1);
  endfunction

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW:0] inc;
    inc = {1'b0, p} + 1'b1;
    return (inc >= (PtrW+1)'(RING_DEPTH)) ? '0 : inc[PtrW-1:0];
  endfunction

  logic [QlenW-1:0]    ring_len_q;
  logic [NumRings-1:0] nonempty_q;
  logic [NumRings-1:0] ptr_vld_q;
  logic [RecW-1:0]     ptr_mem [NumRings];
  logic [StoreW-1:0]   store_mem [StoreDepth];

  logic [RingW-1:0]  home, other, target;
  logic [NumRings-1:0] other_mask;
  logic              home_nonempty;

  logic              deq_q;
  logic [RingW-1:0]  ring_q;
  logic [StoreW-1:0] job_q;
  logic [RecW-1:0]   rec_rd_q;
  logic              rec_vld_q;
  logic [StoreW-1:0] store_rd_q;

  logic [PtrW-1:0]   head, tail, count;
  logic [PtrW-1:0]   cap;
  logic              full;
  logic              ptr_we;
  logic [RecW-1:0]   rec_new;

  logic              done_q, done_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [JobW-1:0]   job_out_q, job_out_d;
  logic [UsedW-1:0]  ring_used_q, ring_used_d;

  // Ring selection for the request on the ports.
  always_comb begin
    home = (thread_id_i < TidW'(PREFERRED_RINGS)) ? RingW'(thread_id_i)
                                                  : RingW'(PREFERRED_RINGS);
    home_nonempty = nonempty_q[home];
    other_mask = nonempty_q;
    other_mask[home] = 1'b0;
    other = '0;
    for (int r = NumRings - 1; r >= 0; r--) begin
      if (other_mask[r]) begin
        other = RingW'(r);
      end
    end
    if (func_i == FuncDeq && !home_nonempty) begin
      target = other;
    end else begin
      target = home;
    end
  end

  assign stat_o.item_deq   = (func_i == FuncDeq);
  assign stat_o.none_found = !home_nonempty && (other_mask == '0);
  assign stat_o.deq_q      = deq_q;

  // Pointer record of the selected ring; a never-written record reads as zero.
  assign {head, tail, count} = rec_vld_q ? rec_rd_q : '0;
  assign cap    = ring_cap(ring_len_q);
  assign full   = (deq_q == FuncEnq) && (count >= cap);
  assign ptr_we = cmd_i.ptr_step && !full;

  always_comb begin
    if (deq_q == FuncDeq) begin
      rec_new = {next_slot(head), tail, count - 1'b1};
    end else begin
      rec_new = {head, next_slot(tail), count + 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len_q <= QlenReset;
      nonempty_q <= '0;
      ptr_vld_q  <= '0;
      rec_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ring_len_q <= cfg_ring_len_i;
      end
      if (cmd_i.load) begin
        rec_vld_q <= ptr_vld_q[target];
      end
      if (ptr_we) begin
        ptr_vld_q[ring_q]  <= 1'b1;
        nonempty_q[ring_q] <= (deq_q == FuncEnq) || (count != PtrW'(1));
      end
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deq_q    <= func_i;
      ring_q   <= target;
      job_q    <= StoreW'(job_id_i);
      rec_rd_q <= ptr_mem[target];
    end
    if (ptr_we) begin
      ptr_mem[ring_q] <= rec_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we && deq_q == FuncEnq) begin
      store_mem[{ring_q, tail}] <= job_q;
    end
    if (ptr_we && deq_q == FuncDeq) begin
      store_rd_q <= store_mem[{ring_q, head}];
    end
  end

  // Result registers.
  always_comb begin
    done_d      = 1'b0;
    status_d    = status_q;
    job_out_d   = job_out_q;
    ring_used_d = ring_used_q;
    priority if (cmd_i.load && func_i == FuncDeq && stat_o.none_found) begin
      done_d      = 1'b1;
      status_d    = StatEmpty;
      job_out_d   = '0;
      ring_used_d = UsedW'(home);
    end else if (cmd_i.ptr_step && deq_q == FuncEnq) begin
      done_d      = 1'b1;
      status_d    = full ? StatFull : StatEnqueued;
      job_out_d   = '0;
      ring_used_d = UsedW'(ring_q);
    end else if (cmd_i.data_step) begin
      done_d      = 1'b1;
      status_d    = StatDequeued;
      job_out_d   = JobW'(store_rd_q);
      ring_used_d = UsedW'(ring_q);
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    job_out_q   <= job_out_d;
    ring_used_q <= ring_used_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign job_out_o   = job_out_q;
  assign ring_used_o = ring_used_q;

endmodule

[hdl/multi_ring_job_dispatcher.sv]
// From the accepting edge, a dequeue that finds every ring empty is answered from idle, an
// enqueue goes through ST_PTR and a dequeue through ST_PTR and ST_DATA; busy is low again as
// done_o rises. The pointer memory read and, on a dequeue, the job memory read are registered.
// Each result is shown for one cycle on done_o; the receiver cannot stall.
// Reset clears all ring pointers and counts and sets the ring length to 64; job storage is
// not cleared.
module multi_ring_job_dispatcher
  import mrjd_pkg::*;
#(
  parameter int unsigned PREFERRED_RINGS = 8,
  parameter int unsigned RING_DEPTH      = 64,
  parameter int unsigned JOB_ID_BITS     = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [QlenW-1:0] cfg_ring_len_i,
  input  logic             start,
  output logic             busy,
  input  logic             func_i,
  input  logic [TidW-1:0]  thread_id_i,
  input  logic [JobW-1:0]  job_id_i,
  output logic             done_o,
  output logic [StatW-1:0] status_o,
  output logic [JobW-1:0]  job_out_o,
  output logic [UsedW-1:0] ring_used_o
);

  mrjd_cmd_t  cmd;
  mrjd_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mrjd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  mrjd_datapath #(
    .PREFERRED_RINGS (PREFERRED_RINGS),
    .RING_DEPTH      (RING_DEPTH),
    .JOB_ID_BITS     (JOB_ID_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ring_len_i  (cfg_ring_len_i),
    .func_i          (func_i),
    .thread_id_i     (thread_id_i),
    .job_id_i        (job_id_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_o          (done_o),
    .status_o        (status_o),
    .job_out_o       (job_out_o),
    .ring_used_o     (ring_used_o)
  );

endmodule

[dv/multi_ring_job_dispatcher_test.sv]
// Self-checking testbench for the multi-ring job dispatcher: directed and random requests.
module multi_ring_job_dispatcher_test
  import mrjd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrefRings  = 8;
  localparam int NumRings   = PrefRings + 1;
  localparam int RingDepth  = 64;
  localparam int CycleLimit = 200000;
  localparam int PhaseLen   = 50;

  typedef struct {
    logic            func;
    logic [TidW-1:0] tid;
    logic [JobW-1:0] job;
  } job_req_t;

  typedef struct {
    logic [StatW-1:0] status;
    logic [JobW-1:0]  job;
    logic [UsedW-1:0] ring;
  } job_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [QlenW-1:0] cfg_ring_len_i = '0;
  logic             start = 1'b0;
  logic             busy;
  logic             func_i = FuncEnq;
  logic [TidW-1:0]  thread_id_i = '0;
  logic [JobW-1:0]  job_id_i = '0;
  logic             done_o;
  logic [StatW-1:0] status_o;
  logic [JobW-1:0]  job_out_o;
  logic [UsedW-1:0] ring_used_o;

  // Shadow copy of the rings and the ring length register.
  logic [JobW-1:0]  ring_jobs [NumRings][RingDepth];
  int               ring_rd   [NumRings];
  int               ring_wr   [NumRings];
  int               ring_fill [NumRings];
  logic [QlenW-1:0] model_qlen = QlenReset;

  job_req_t    job_requests[$];
  job_result_t pending_outcomes[$];

  int  queued_total = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  cfg_writes = 0;
  int  n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0;
  int  wait_left = 0;
  bit  no_idle = 1'b0;

  multi_ring_job_dispatcher #(
    .PREFERRED_RINGS(PrefRings),
    .RING_DEPTH     (RingDepth),
    .JOB_ID_BITS    (JobW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_ring_len_i (cfg_ring_len_i),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .thread_id_i    (thread_id_i),
    .job_id_i       (job_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .job_out_o      (job_out_o),
    .ring_used_o    (ring_used_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int ring_capacity(logic [QlenW-1:0] len);
    int size;
    size = 4;
    while (size < len && size < RingDepth) size = size * 2;
    if (size > RingDepth) size = RingDepth;
    return size - 1;
  endfunction

  // Applies one request to the shadow rings and returns what the block should report.
  function automatic job_result_t dispatch_outcome(logic func, logic [TidW-1:0] tid,
                                                   logic [JobW-1:0] job);
    job_result_t res;
    int home;
    int src;
    home = (tid < PrefRings) ? int'(tid) : PrefRings;
    res.status = StatEmpty;
    res.job = '0;
    res.ring = UsedW'(home);
    src = -1;
    if (func == FuncEnq) begin
      if (ring_fill[home] >= ring_capacity(model_qlen)) begin
        res.status = StatFull;
      end else begin
        ring_jobs[home][ring_wr[home]] = job;
        ring_wr[home] = (ring_wr[home] + 1) % RingDepth;
        ring_fill[home]++;
        res.status = StatEnqueued;
      end
    end else begin
      if (ring_fill[home] != 0) src = home;
      for (int k = 0; k < NumRings; k++) begin
        if (src < 0 && k != home && ring_fill[k] != 0) src = k;
      end
      if (src >= 0) begin
        res.status = StatDequeued;
        res.job = ring_jobs[src][ring_rd[src]];
        res.ring = UsedW'(src);
        ring_rd[src] = (ring_rd[src] + 1) % RingDepth;
        ring_fill[src]--;
      end
    end
    return res;
  endfunction

  // Request driver: holds start until the block takes the request, then idles at random.
  always @(posedge clk_i) begin : drive
    logic     presenting;
    job_req_t req;
    presenting = start;
    if (rst_ni) begin
      if (start && !busy) begin
        pending_outcomes.push_back(dispatch_outcome(func_i, thread_id_i, job_id_i));
        case (pending_outcomes[$].status)
          StatEnqueued: n_enq++;
          StatFull:     n_full++;
          StatDequeued: n_deq++;
          default:      n_empty++;
        endcase
        presenting = 1'b0;
        if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
        wait_left = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (!presenting) begin
        if (wait_left > 0) begin
          wait_left--;
        end else if (job_requests.size() > 0) begin
          req = job_requests.pop_front();
          presenting = 1'b1;
          func_i <= req.func;
          thread_id_i <= req.tid;
          job_id_i <= req.job;
        end
      end
      start <= presenting;
    end
  end

  // Result monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin : check
    job_result_t exp;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d job_out %0h ring_used %0d",
               status_o, job_out_o, ring_used_o);
        mismatches++;
      end else begin
        exp = pending_outcomes.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          mismatches++;
        end
        if (job_out_o !== exp.job) begin
          $error("job_out: expected %0h, got %0h", exp.job, job_out_o);
          mismatches++;
        end
        if (ring_used_o !== exp.ring) begin
          $error("ring_used: expected %0d, got %0d", exp.ring, ring_used_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void push_request(logic func, logic [TidW-1:0] tid,
                                       logic [JobW-1:0] job);
    job_req_t r;
    r.func = func;
    r.tid = tid;
    r.job = job;
    job_requests.push_back(r);
    queued_total++;
  endfunction

  // Most requests go to one thread of the phase so that its ring fills or drains.
  function automatic void push_random(logic [TidW-1:0] focus, int enq_pct);
    int pick;
    logic [TidW-1:0] tid;
    pick = $urandom_range(0, 99);
    if (pick < 55) tid = focus;
    else if (pick < 90) tid = TidW'($urandom_range(0, 9));
    else tid = TidW'($urandom_range(0, 255));
    push_request(($urandom_range(0, 99) < enq_pct) ? FuncEnq : FuncDeq, tid, $urandom());
  endfunction

  task automatic wait_idle();
    while (results_seen < queued_total) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ring_len(logic [QlenW-1:0] len);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_ring_len_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_qlen = len;
    cfg_writes++;
  endtask

  initial begin
    logic [QlenW-1:0] lens[11];
    logic [TidW-1:0]  focus;
    int               enq_pct;
    lens = '{7'd127, 7'd4, 7'd0, 7'd64, 7'd9, 7'd1, 7'd33, 7'd100, 7'd16, 7'd2, 7'd65};
    for (int r = 0; r < NumRings; r++) begin
      ring_rd[r] = 0;
      ring_wr[r] = 0;
      ring_fill[r] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty rings, home first, stealing from the lowest other ring, and the shared ring.
    push_request(FuncDeq, 8'd0, 32'h1111_1111);
    push_request(FuncDeq, 8'd255, 32'h0);
    push_request(FuncEnq, 8'd0, 32'h0000_0000);
    push_request(FuncEnq, 8'd0, 32'hFFFF_FFFF);
    push_request(FuncEnq, 8'd255, 32'hA5A5_5A5A);
    push_request(FuncEnq, 8'd8, 32'h1234_5678);
    push_request(FuncEnq, 8'd3, 32'h8000_0001);
    push_request(FuncDeq, 8'd0, 32'h0);
    push_request(FuncDeq, 8'd0, 32'h0);
    push_request(FuncDeq, 8'd0, 32'h0);
    push_request(FuncDeq, 8'd7, 32'h0);
    push_request(FuncDeq, 8'd200, 32'h0);
    push_request(FuncDeq, 8'd1, 32'hFFFF_FFFF);
    wait_idle();

    // Smallest capacity: the fourth job into one ring is refused.
    write_ring_len(7'd0);
    for (int i = 0; i < 4; i++) push_request(FuncEnq, 8'd5, 32'hC000_0000 + i);
    push_request(FuncEnq, 8'd127, 32'h7F7F_7F7F);
    push_request(FuncDeq, 8'd5, 32'h0);
    push_request(FuncEnq, 8'd5, 32'h5555_AAAA);
    wait_idle();

    // Random phases; rings keep their jobs across length changes, so shrinking
    // the capacity under a full ring is exercised too.
    for (int p = 0; p < $size(lens); p++) begin
      write_ring_len(lens[p]);
      focus = $urandom_range(0, 1) ? TidW'($urandom_range(0, 8)) : TidW'($urandom_range(8, 255));
      enq_pct = (p % 3 == 0) ? 85 : ((p % 3 == 1) ? 35 : 55);
      for (int i = 0; i < PhaseLen; i++) push_random(focus, enq_pct);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("Ran %0d requests over %0d ring length writes: %0d enqueued, %0d full,",
             queued_total, cfg_writes, n_enq, n_full);
    $display("%0d dequeued, %0d found every ring empty.", n_deq, n_empty);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[multi_ring_job_dispatcher.f]
hdl/mrjd_pkg.sv
hdl/mrjd_ctrl.sv
hdl/mrjd_datapath.sv
hdl/multi_ring_job_dispatcher.sv
dv/multi_ring_job_dispatcher_test.sv
